>>> rtl/core/playback_starvation_ledger_unit_defines.svh
// Assertion macros used by the playback starvation ledger top level.
`ifndef PLAYBACK_STARVATION_LEDGER_UNIT_DEFINES_SVH
`define PLAYBACK_STARVATION_LEDGER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PSL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ledger check failed");

// Next-cycle implication, checked outside reset.
`define PSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ledger check failed");

`endif

>>> rtl/core/psl_pkg.sv
// Types, constants and helpers for the playback starvation ledger.
package psl_pkg;

    localparam int TIME_BITS_DEF = 48;
    localparam int RING_BITS     = 10;
    localparam int AMOUNT_BITS   = 16;
    localparam int CNT_BITS      = 32;
    localparam int DL_BITS       = 64;

    localparam logic [RING_BITS-1:0] RING_RESET = 10'd40;
    localparam logic [CNT_BITS-1:0]  SAT32      = 32'hffff_ffff;

    // amount_ms * 1000 and ring_length_ms * 1000 fit these widths
    localparam int AMT_US_BITS  = 26;
    localparam int RING_US_BITS = 20;
    localparam logic [AMT_US_BITS-1:0]  US_PER_MS_A = 26'd1000;
    localparam logic [RING_US_BITS-1:0] US_PER_MS_R = 20'd1000;

    // Lateness at or above 1000 * 2^32 us saturates; below it fits 42 bits.
    localparam logic [DL_BITS-1:0] LATE_SAT_US = 64'd1000 << 32;
    localparam int LATE_BITS = 42;

    // Divide by 1000 via reciprocal: q = (x * DIV_MAGIC) >> DIV_SHIFT, exact for x < 2^42.
    localparam int DIV_SHIFT  = 52;
    localparam int MAGIC_BITS = 43;
    localparam logic [63:0] DIV_MAGIC_64 = ((64'd1 << DIV_SHIFT) + 64'd999) / 64'd1000;
    localparam logic [MAGIC_BITS-1:0] DIV_MAGIC = DIV_MAGIC_64[MAGIC_BITS-1:0];
    localparam int XL_BITS  = 21;
    localparam int XH_BITS  = LATE_BITS - XL_BITS;
    localparam int ML_BITS  = 22;
    localparam int MH_BITS  = MAGIC_BITS - ML_BITS;
    localparam int PROD_BITS = LATE_BITS + MAGIC_BITS;

    typedef enum logic [2:0] {
        OP_WATCH    = 3'd0,
        OP_DRAIN    = 3'd1,
        OP_FLUSH    = 3'd2,
        OP_CREDIT   = 3'd3,
        OP_ROLLBACK = 3'd4
    } t_opcode;

    // Per-transaction values that ride along the lateness pipeline
    typedef struct packed {
        logic                seen;
        logic [CNT_BITS-1:0] credited;
        logic [CNT_BITS-1:0] events;
    } t_meta;

    typedef struct packed {
        t_meta                meta;
        logic                 sat;
        logic [LATE_BITS-1:0] diff;
    } t_s1;

    function automatic logic [CNT_BITS-1:0] sat_add32(input logic [CNT_BITS-1:0] a,
                                                      input logic [CNT_BITS-1:0] b);
        logic [CNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_BITS] ? SAT32 : s[CNT_BITS-1:0];
    endfunction

endpackage

>>> rtl/core/psl_state.sv
// Ledger state: watch flags, deadline, credit and starvation count update.
module psl_state #(
    parameter int TIME_BITS = psl_pkg::TIME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [psl_pkg::RING_BITS-1:0]   i_cfg_data,
    input  logic                            i_accept,
    input  logic [2:0]                      i_opcode,
    input  logic                            i_active,
    input  logic [psl_pkg::AMOUNT_BITS-1:0] i_amount_ms,
    input  logic [TIME_BITS-1:0]            i_now_us,
    output psl_pkg::t_s1                    o_s1
);

    logic [psl_pkg::RING_BITS-1:0] r_ring;
    logic                          r_watching, n_watching;
    logic                          r_drain, n_drain;
    logic                          r_stale, n_stale;
    logic [psl_pkg::DL_BITS-1:0]   r_deadline, n_deadline;
    logic [psl_pkg::CNT_BITS-1:0]  r_credited, n_credited;
    logic [psl_pkg::CNT_BITS-1:0]  r_events, n_events;
    psl_pkg::t_s1                  r_s1, n_s1;

    logic [psl_pkg::DL_BITS-1:0]      now64;
    logic [psl_pkg::DL_BITS-1:0]      diff;
    logic [psl_pkg::AMT_US_BITS-1:0]  amt_us;
    logic [psl_pkg::RING_US_BITS-1:0] ring_us;
    logic                             armed;
    logic                             now_late;
    logic                             starve;

    always_comb begin
        now64    = psl_pkg::DL_BITS'(i_now_us);
        amt_us   = psl_pkg::AMT_US_BITS'(i_amount_ms) * psl_pkg::US_PER_MS_A;
        ring_us  = psl_pkg::RING_US_BITS'(r_ring) * psl_pkg::US_PER_MS_R;
        armed    = $signed(r_deadline) > $signed(64'd0);
        now_late = $signed(now64) > $signed(r_deadline);
        diff     = now64 - r_deadline;
        starve   = r_watching && !r_drain && armed && now_late &&
                   (r_credited >= psl_pkg::CNT_BITS'(r_ring));
    end

    always_comb begin
        n_watching = r_watching;
        n_drain    = r_drain;
        n_stale    = r_stale;
        n_deadline = r_deadline;
        n_credited = r_credited;
        n_events   = r_events;
        n_s1.meta.seen = 1'b0;
        case (psl_pkg::t_opcode'(i_opcode))
            psl_pkg::OP_WATCH: begin
                if (i_active && !r_watching) begin
                    n_credited = '0;
                    n_deadline = now64 +
                        (r_stale ? psl_pkg::DL_BITS'(ring_us) : psl_pkg::DL_BITS'(0));
                    n_stale    = 1'b0;
                end
                if (i_active) begin
                    n_drain = 1'b0;
                end
                n_watching = i_active;
            end
            psl_pkg::OP_DRAIN: begin
                n_drain = 1'b1;
            end
            psl_pkg::OP_FLUSH: begin
                n_stale = 1'b1;
            end
            psl_pkg::OP_CREDIT: begin
                if (starve) begin
                    n_events       = psl_pkg::sat_add32(r_events, 32'd1);
                    n_s1.meta.seen = 1'b1;
                end
                n_deadline = (now_late ? now64 : r_deadline) + psl_pkg::DL_BITS'(amt_us);
                n_credited = psl_pkg::sat_add32(r_credited,
                                                psl_pkg::CNT_BITS'(i_amount_ms));
            end
            psl_pkg::OP_ROLLBACK: begin
                n_deadline = r_deadline - psl_pkg::DL_BITS'(amt_us);
                if (r_credited >= psl_pkg::CNT_BITS'(i_amount_ms)) begin
                    n_credited = r_credited - psl_pkg::CNT_BITS'(i_amount_ms);
                end
            end
            default: begin
            end
        endcase
        n_s1.meta.credited = n_credited;
        n_s1.meta.events   = n_events;
        n_s1.sat           = diff >= psl_pkg::LATE_SAT_US;
        n_s1.diff          = diff[psl_pkg::LATE_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring     <= psl_pkg::RING_RESET;
            r_watching <= 1'b0;
            r_drain    <= 1'b0;
            r_stale    <= 1'b0;
            r_deadline <= '0;
            r_credited <= '0;
            r_events   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_ring <= i_cfg_data;
            end
            if (i_accept) begin
                r_watching <= n_watching;
                r_drain    <= n_drain;
                r_stale    <= n_stale;
                r_deadline <= n_deadline;
                r_credited <= n_credited;
                r_events   <= n_events;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

>>> rtl/core/playback_starvation_ledger_unit.sv
// Playback starvation ledger: top level with lateness divide pipeline and output register.
// o_valid rises once the transaction has passed the state register, two divide stages and the output register.
// Throughput: one transaction per cycle while no stage is held by i_ready; state updates at accept.
// Lateness / 1000 is a reciprocal multiply split into four partial products over two stages.
// Reset (synchronous, active low) clears ledger state, valid bits; ring length returns to 40.
`include "playback_starvation_ledger_unit_defines.svh"

module playback_starvation_ledger_unit #(
    parameter int TIME_BITS = psl_pkg::TIME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [psl_pkg::RING_BITS-1:0]   i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [2:0]                      i_opcode,
    input  logic                            i_active,
    input  logic [psl_pkg::AMOUNT_BITS-1:0] i_amount_ms,
    input  logic [TIME_BITS-1:0]            i_now_us,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [psl_pkg::CNT_BITS-1:0]    o_starved_total_ms,
    output logic [psl_pkg::CNT_BITS-1:0]    o_starve_count,
    output logic [psl_pkg::CNT_BITS-1:0]    o_credited_total_ms,
    output logic                            o_starve_seen
);

    localparam int XL = psl_pkg::XL_BITS;
    localparam int XH = psl_pkg::XH_BITS;
    localparam int ML = psl_pkg::ML_BITS;
    localparam int MH = psl_pkg::MH_BITS;
    localparam int PB = psl_pkg::PROD_BITS;
    localparam int CB = psl_pkg::CNT_BITS;

    localparam logic [ML-1:0] MAGIC_LO = psl_pkg::DIV_MAGIC[ML-1:0];
    localparam logic [MH-1:0] MAGIC_HI = psl_pkg::DIV_MAGIC[psl_pkg::MAGIC_BITS-1:ML];

    psl_pkg::t_s1   s1;
    logic           accept;
    logic           rdy1, rdy2, rdy3, rdy_out;

    logic           r_v1, r_v2, r_v3, r_out_valid;
    psl_pkg::t_meta r_meta2, r_meta3;
    logic           r_sat2;
    logic [XL+ML-1:0] r_pp_ll;
    logic [XL+MH-1:0] r_pp_lh;
    logic [XH+ML-1:0] r_pp_hl;
    logic [XH+MH-1:0] r_pp_hh;
    logic [CB-1:0]  r_late3;
    logic [PB-1:0]  prod;
    logic [CB-1:0]  r_starved, r_events, r_credited;
    logic           r_seen;

    assign o_cfg_ready = 1'b1;

    // ready chain: a stage takes new data when empty or when it is moving on
    assign rdy_out = !r_out_valid || i_ready;
    assign rdy3    = !r_v3 || rdy_out;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign accept  = i_valid && rdy1;

    psl_state #(
        .TIME_BITS (TIME_BITS)
    ) u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_opcode    (i_opcode),
        .i_active    (i_active),
        .i_amount_ms (i_amount_ms),
        .i_now_us    (i_now_us),
        .o_s1        (s1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
            r_starved   <= '0;
        end else begin
            if (rdy1) begin
                r_v1 <= accept;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy_out) begin
                r_out_valid <= r_v3;
                if (r_v3 && r_meta3.seen) begin
                    r_starved <= psl_pkg::sat_add32(r_starved, r_late3);
                end
            end
        end
    end

    // partial products of lateness * reciprocal
    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_meta2 <= s1.meta;
            r_sat2  <= s1.sat;
            r_pp_ll <= (XL+ML)'(s1.diff[XL-1:0]) * (XL+ML)'(MAGIC_LO);
            r_pp_lh <= (XL+MH)'(s1.diff[XL-1:0]) * (XL+MH)'(MAGIC_HI);
            r_pp_hl <= (XH+ML)'(s1.diff[psl_pkg::LATE_BITS-1:XL]) * (XH+ML)'(MAGIC_LO);
            r_pp_hh <= (XH+MH)'(s1.diff[psl_pkg::LATE_BITS-1:XL]) * (XH+MH)'(MAGIC_HI);
        end
    end

    assign prod = (PB'(r_pp_hh) << (XL + ML)) + (PB'(r_pp_hl) << XL) +
                  (PB'(r_pp_lh) << ML) + PB'(r_pp_ll);

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_meta3 <= r_meta2;
            r_late3 <= r_sat2 ? psl_pkg::SAT32
                              : prod[psl_pkg::DIV_SHIFT+CB-1:psl_pkg::DIV_SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_out && r_v3) begin
            r_events   <= r_meta3.events;
            r_credited <= r_meta3.credited;
            r_seen     <= r_meta3.seen;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_starved_total_ms  = r_starved;
    assign o_starve_count      = r_events;
    assign o_credited_total_ms = r_credited;
    assign o_starve_seen       = r_seen;

    `PSL_ASSERT_IMPL(a_seen_counted, i_clk, i_rst_n, o_valid && o_starve_seen, o_starve_count != 32'd0)
    `PSL_ASSERT_NEXT(a_starved_mono, i_clk, i_rst_n, 1'b1, r_starved >= $past(r_starved))
    `PSL_ASSERT_IMPL(a_full_stall, i_clk, i_rst_n, r_v1 && r_v2 && r_v3 && r_out_valid && !i_ready, !o_ready)
    `PSL_ASSERT_NEXT(a_seen_credit, i_clk, i_rst_n, accept && (i_opcode != psl_pkg::OP_CREDIT), !s1.meta.seen)

endmodule

>>> tb/tb_playback_starvation_ledger_unit.sv
// Self-checking testbench for the playback starvation ledger unit.
module tb_playback_starvation_ledger_unit;
    import psl_pkg::*;

    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
    localparam logic [63:0] US_PER_MS = 64'd1000;
    localparam logic [31:0] CNT_MAX = 32'hffff_ffff;
    localparam logic [47:0] NOW_MAX = 48'hffff_ffff_ffff;

    typedef struct {
        logic [31:0] starved;
        logic [31:0] count;
        logic [31:0] credited;
        logic        seen;
    } ledger_result_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [RING_BITS-1:0]   i_cfg_data = '0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic [2:0]             i_opcode = '0;
    logic                   i_active = 1'b0;
    logic [AMOUNT_BITS-1:0] i_amount_ms = '0;
    logic [47:0]            i_now_us = '0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic [CNT_BITS-1:0]    o_starved_total_ms;
    logic [CNT_BITS-1:0]    o_starve_count;
    logic [CNT_BITS-1:0]    o_credited_total_ms;
    logic                   o_starve_seen;

    // ledger mirror
    logic [RING_BITS-1:0] ring_len_ms = RING_RESET;
    bit                   watch_on = 1'b0;
    bit                   drain_on = 1'b0;
    bit                   flush_pending = 1'b0;
    logic [63:0]          deadline_us = '0;
    logic [31:0]          credit_ms = '0;
    logic [31:0]          starved_ms_total = '0;
    logic [31:0]          starve_cnt = '0;

    ledger_result_t pending_results[$];
    int             error_count = 0;
    int             events_sent = 0;
    bit             no_idle = 1'b0;
    logic [47:0]    tb_now = '0;

    playback_starvation_ledger_unit u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_opcode            (i_opcode),
        .i_active            (i_active),
        .i_amount_ms         (i_amount_ms),
        .i_now_us            (i_now_us),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_starved_total_ms  (o_starved_total_ms),
        .o_starve_count      (o_starve_count),
        .o_credited_total_ms (o_credited_total_ms),
        .o_starve_seen       (o_starve_seen)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= no_idle || ($urandom_range(0, 99) >= 10);
    end

    function automatic logic [31:0] add_clamped(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? CNT_MAX : s[31:0];
    endfunction

    // Advances the mirrored ledger by one event and returns the totals it reports.
    function automatic ledger_result_t apply_event(logic [2:0] op, bit act,
                                                   logic [15:0] amt, logic [47:0] now_in);
        ledger_result_t r;
        logic [63:0]    now;
        logic [63:0]    late;
        logic [63:0]    base;
        bit             hit;
        now = {16'd0, now_in};
        hit = 1'b0;
        case (op)
            OP_WATCH: begin
                if (act && !watch_on) begin
                    credit_ms = '0;
                    deadline_us = now + (flush_pending ? 64'(ring_len_ms) * US_PER_MS : 64'd0);
                    flush_pending = 1'b0;
                end
                if (act) drain_on = 1'b0;
                watch_on = act;
            end
            OP_DRAIN: drain_on = 1'b1;
            OP_FLUSH: flush_pending = 1'b1;
            OP_CREDIT: begin
                if (watch_on && !drain_on && $signed(deadline_us) > 0 &&
                    credit_ms >= 32'(ring_len_ms) && $signed(now) > $signed(deadline_us)) begin
                    late = (now - deadline_us) / US_PER_MS;
                    starved_ms_total = add_clamped(starved_ms_total,
                                                   (late > 64'(CNT_MAX)) ? CNT_MAX : late[31:0]);
                    starve_cnt = add_clamped(starve_cnt, 32'd1);
                    hit = 1'b1;
                end
                base = ($signed(now) > $signed(deadline_us)) ? now : deadline_us;
                deadline_us = base + 64'(amt) * US_PER_MS;
                credit_ms = add_clamped(credit_ms, 32'(amt));
            end
            OP_ROLLBACK: begin
                deadline_us = deadline_us - 64'(amt) * US_PER_MS;
                if (credit_ms >= 32'(amt)) credit_ms = credit_ms - 32'(amt);
            end
            default: ;
        endcase
        r.starved = starved_ms_total;
        r.count = starve_cnt;
        r.credited = credit_ms;
        r.seen = hit;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t ERROR %s expected %0d actual %0d", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        ledger_result_t exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t ERROR unexpected result expected none actual %0d/%0d/%0d/%0d",
                         $time, o_starved_total_ms, o_starve_count,
                         o_credited_total_ms, o_starve_seen);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                check_field("starved_total_ms", exp_r.starved, o_starved_total_ms);
                check_field("starve_count", exp_r.count, o_starve_count);
                check_field("credited_total_ms", exp_r.credited, o_credited_total_ms);
                check_field("starve_seen", 32'(exp_r.seen), 32'(o_starve_seen));
            end
        end
    end

    task automatic send_event(logic [2:0] op, bit act, logic [15:0] amt, logic [47:0] now);
        if (!no_idle && $urandom_range(0, 99) < 5) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= op;
        i_active <= act;
        i_amount_ms <= amt;
        i_now_us <= now;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(apply_event(op, act, amt, now));
        events_sent++;
    endtask

    task automatic wait_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_ring_length(logic [RING_BITS-1:0] v);
        wait_results();
        repeat (6) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        ring_len_ms = v;
    endtask

    // Watch sessions: mostly credits around the ring size, with time running ahead
    // often enough that credits land late.
    task automatic run_sessions(int n_items);
        int          target;
        int          pick;
        int          amt_hi;
        logic [15:0] amt;
        target = events_sent + n_items;
        amt_hi = int'(ring_len_ms) + 20;
        send_event(OP_WATCH, 1'b0, 16'($urandom), tb_now);
        while (events_sent < target) begin
            if ($urandom_range(0, 1)) send_event(OP_FLUSH, 1'($urandom), 16'($urandom), tb_now);
            tb_now += 48'($urandom_range(0, 5000));
            send_event(OP_WATCH, 1'b1, 16'($urandom), tb_now);
            repeat ($urandom_range(4, 20)) begin
                pick = $urandom_range(0, 99);
                amt = 16'($urandom_range(1, amt_hi));
                tb_now += 48'($urandom_range(0, amt_hi * 1500));
                if (pick < 70)
                    send_event(OP_CREDIT, 1'($urandom), amt, tb_now);
                else if (pick < 78)
                    send_event(OP_ROLLBACK, 1'($urandom), 16'($urandom_range(0, amt_hi)), tb_now);
                else if (pick < 84)
                    send_event(OP_DRAIN, 1'($urandom), 16'($urandom), tb_now);
                else if (pick < 89)
                    send_event(OP_WATCH, 1'b1, 16'($urandom), tb_now);
                else if (pick < 92)
                    send_event(OP_FLUSH, 1'($urandom), 16'($urandom), tb_now);
                else if (pick < 95)
                    send_event(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)),
                               1'($urandom), 16'($urandom), tb_now);
                else
                    send_event(3'($urandom_range(0, 7)), 1'($urandom), 16'($urandom), tb_now);
            end
            if ($urandom_range(0, 4) != 0) send_event(OP_WATCH, 1'b0, 16'($urandom), tb_now);
        end
    endtask

    task automatic test_directed();
        send_event(OP_UNUSED_FIRST, 1'b1, 16'hffff, NOW_MAX);
        send_event(OP_UNUSED_LAST, 1'b0, 16'd0, 48'd0);
        send_event(OP_CREDIT, 1'b1, 16'd0, 48'd0);           // credit while not watching
        send_event(OP_ROLLBACK, 1'b0, 16'd5, 48'd100);       // deadline goes negative
        send_event(OP_FLUSH, 1'b1, 16'd0, 48'd200);
        send_event(OP_WATCH, 1'b1, 16'd0, 48'd1000);         // armed one ring out
        send_event(OP_DRAIN, 1'b0, 16'd0, 48'd1500);
        send_event(OP_WATCH, 1'b1, 16'd0, 48'd1600);         // re-watch clears draining only
        send_event(OP_CREDIT, 1'b0, 16'd40, 48'd2000);
        send_event(OP_CREDIT, 1'b0, 16'd10, 48'd200500);
        send_event(OP_DRAIN, 1'b1, 16'd0, 48'd300000);
        send_event(OP_CREDIT, 1'b0, 16'd20, 48'd900000);
        send_event(OP_WATCH, 1'b1, 16'd0, 48'd900100);
        send_event(OP_ROLLBACK, 1'b0, 16'hffff, 48'd900200); // more than credited
        send_event(OP_CREDIT, 1'b0, 16'd5, 48'd950000);      // unarmed
        send_event(OP_ROLLBACK, 1'b0, 16'd5, 48'd950100);
        send_event(OP_CREDIT, 1'b1, 16'd1, 48'd2000000);
        send_event(OP_WATCH, 1'b0, 16'd0, 48'd2000100);
        send_event(OP_CREDIT, 1'b0, 16'd3, 48'd9000000);
        send_event(OP_WATCH, 1'b1, 16'd0, 48'd9000000);
        send_event(OP_CREDIT, 1'b0, 16'd39, 48'd9500000);
        send_event(OP_CREDIT, 1'b0, 16'd1, 48'd20000000);
        send_event(OP_CREDIT, 1'b0, 16'd1, 48'd30000000);    // credit exactly one ring
        tb_now = 48'd30000000;
    endtask

    task automatic test_ring_settings();
        logic [RING_BITS-1:0] rings[5];
        rings = '{10'd1, 10'd1000, 10'd0, 10'd1023, 10'($urandom_range(2, 999))};
        foreach (rings[k]) begin
            write_ring_length(rings[k]);
            run_sessions(200);
        end
        write_ring_length(RING_RESET);
    endtask

    task automatic test_pause_for_results();
        run_sessions(60);
        wait_results();
        run_sessions(60);
    endtask

    task automatic test_no_idle_stretch();
        wait_results();
        no_idle = 1'b1;
        run_sessions(200);
        no_idle = 1'b0;
    endtask

    // Unstructured transactions over the full field ranges, times jumping anywhere.
    task automatic test_noise();
        repeat (250) begin
            send_event(3'($urandom_range(0, 7)), 1'($urandom), 16'($urandom),
                       48'({$urandom, $urandom}));
        end
    endtask

    task automatic test_huge_lateness();
        send_event(OP_WATCH, 1'b0, 16'd0, 48'd0);
        send_event(OP_WATCH, 1'b1, 16'd0, 48'd5);
        send_event(OP_CREDIT, 1'b0, 16'hffff, 48'd10);
        send_event(OP_CREDIT, 1'b0, 16'd1, NOW_MAX);
        send_event(OP_CREDIT, 1'b0, 16'd1, NOW_MAX);
        send_event(OP_ROLLBACK, 1'b0, 16'hffff, NOW_MAX);
        send_event(OP_ROLLBACK, 1'b0, 16'hffff, NOW_MAX);
        send_event(OP_CREDIT, 1'b0, 16'd2, NOW_MAX);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_ring_settings();
        test_pause_for_results();
        test_no_idle_stretch();
        test_noise();
        test_huge_lateness();
        wait_results();
        repeat (10) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/psl_pkg.sv
rtl/core/psl_state.sv
rtl/core/playback_starvation_ledger_unit.sv
tb/tb_playback_starvation_ledger_unit.sv
